### rtl/core/slrg_pkg.sv
// slrg_pkg: shared constants, control word and status types, and the microcode
// ROM for the shuffled Lehmer generator. No dependencies.
`timescale 1ns / 1ps

package slrg_pkg;

    localparam logic [14:0] LCG_MUL      = 15'd16807;
    localparam logic [30:0] LCG_MOD      = 31'h7FFF_FFFF;
    localparam logic [23:0] FRAC_MAX     = 24'd16777213;
    localparam int          WARMUP_STEPS = 8;

    // Microprogram addresses
    typedef enum logic [3:0] {
        UP_IDLE,
        UP_DISPATCH,
        UP_SEED_LOAD,
        UP_SEED_MUL,
        UP_SEED_FOLD,
        UP_DRAW_MUL,
        UP_DRAW_FOLD,
        UP_LOOK,
        UP_WAIT_OUT,
        UP_EMIT
    } t_upc;

    // Jump conditions; a taken jump loads target, otherwise the step counter advances
    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_NO_ITEM,
        J_NO_SEED,
        J_CNT_NZ,
        J_OUT_BUSY
    } t_jcond;

    typedef struct packed {
        logic   ld_seed;   // state <= sanitized seed, load step count
        logic   mul;       // state * 16807, held * reciprocal
        logic   fold;      // Mersenne reduction into state
        logic   fill;      // write table during seeding, count down
        logic   qmul;      // quotient estimate times bucket size
        logic   look;      // table read and swap-in of new state
        logic   emit;      // load result register
        t_jcond jcond;
        t_upc   target;
    } t_ctrl;

    typedef struct packed {
        logic need_seed;
        logic cnt_zero;
        logic out_busy;
    } t_stat;

    function automatic t_ctrl ucode(input t_upc upc);
        t_ctrl c;
        c = '0;
        c.jcond  = J_NEXT;
        c.target = UP_IDLE;
        case (upc)
            UP_IDLE: begin
                c.jcond  = J_NO_ITEM;
                c.target = UP_IDLE;
            end
            UP_DISPATCH: begin
                c.jcond  = J_NO_SEED;
                c.target = UP_DRAW_MUL;
            end
            UP_SEED_LOAD: begin
                c.ld_seed = 1'b1;
            end
            UP_SEED_MUL: begin
                c.mul = 1'b1;
            end
            UP_SEED_FOLD: begin
                c.fold   = 1'b1;
                c.fill   = 1'b1;
                c.jcond  = J_CNT_NZ;
                c.target = UP_SEED_MUL;
            end
            UP_DRAW_MUL: begin
                c.mul = 1'b1;
            end
            UP_DRAW_FOLD: begin
                c.fold = 1'b1;
                c.qmul = 1'b1;
            end
            UP_LOOK: begin
                c.look = 1'b1;
            end
            UP_WAIT_OUT: begin
                c.jcond  = J_OUT_BUSY;
                c.target = UP_WAIT_OUT;
            end
            UP_EMIT: begin
                c.emit   = 1'b1;
                c.jcond  = J_ALWAYS;
                c.target = UP_IDLE;
            end
            default: begin
                c.jcond  = J_ALWAYS;
                c.target = UP_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

### rtl/core/shuffled_lehmer_random_generator.sv
// Top level of the shuffled Lehmer generator: microcode sequencer plus datapath.
// Depends on slrg_pkg, slrg_seq and slrg_dp.
//
// Park-Miller minimal standard generator (x * 16807 mod 2^31-1) behind a
// Bays-Durham shuffle table of TABLE_DEPTH entries. One input transfer gives
// one result transfer. command = 0 draws; command = 1 reseeds from i_seed
// (0 and 2^31-1 are taken as 1) and then draws; a draw before any seeding
// seeds from 1 first. A draw runs from transfer to result valid through
// one dispatch step and five datapath steps (multiply, Mersenne fold, table
// swap, output register check, result load). The sequencer is back at its
// idle step in the cycle after the result load, and only then takes the
// next draw. A reseed adds a seed load step, then a multiply and a fold step
// for each table entry and each warmup step, since every generator step runs
// through the one multiplier and its fold register. The input is taken
// only while the sequencer sits at its idle step; the result register lets a
// new item in while the previous result still waits on o_valid/i_stall, and
// the output register check step then holds for as long as that result stays
// stalled.
// o_fraction is value/(2^31-1) in Q0.24, truncated, clamped to 16777213.
`timescale 1ns / 1ps

module shuffled_lehmer_random_generator #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [30:0] i_seed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [30:0] o_value,
    output logic [23:0] o_fraction
);

    slrg_pkg::t_ctrl w_ctrl;
    slrg_pkg::t_stat w_stat;
    logic            w_idle;
    logic            w_accept;

    // input transfer only at the idle step of the program
    assign o_stall  = !w_idle;
    assign w_accept = i_valid && w_idle;

    slrg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_idle  (w_idle)
    );

    slrg_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_accept   (w_accept),
        .i_command  (i_command),
        .i_seed     (i_seed),
        .i_stall    (i_stall),
        .o_stat     (w_stat),
        .o_valid    (o_valid),
        .o_value    (o_value),
        .o_fraction (o_fraction)
    );

endmodule

### rtl/core/slrg_seq.sv
// slrg_seq: step counter and microcode ROM lookup with conditional jumps.
// Depends on slrg_pkg.
`timescale 1ns / 1ps

module slrg_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  slrg_pkg::t_stat     i_stat,
    output slrg_pkg::t_ctrl     o_ctrl,
    output logic                o_idle
);

    slrg_pkg::t_upc  r_upc;
    slrg_pkg::t_upc  n_upc;
    slrg_pkg::t_ctrl w_ctrl;
    logic            w_take;

    assign w_ctrl = slrg_pkg::ucode(r_upc);

    always_comb begin
        case (w_ctrl.jcond)
            slrg_pkg::J_NEXT:     w_take = 1'b0;
            slrg_pkg::J_ALWAYS:   w_take = 1'b1;
            slrg_pkg::J_NO_ITEM:  w_take = !i_valid;
            slrg_pkg::J_NO_SEED:  w_take = !i_stat.need_seed;
            slrg_pkg::J_CNT_NZ:   w_take = !i_stat.cnt_zero;
            slrg_pkg::J_OUT_BUSY: w_take = i_stat.out_busy;
            default:              w_take = 1'b1;
        endcase
        n_upc = w_take ? w_ctrl.target : slrg_pkg::t_upc'(r_upc + 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= slrg_pkg::UP_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = w_ctrl;
    assign o_idle = (r_upc == slrg_pkg::UP_IDLE);

endmodule

### rtl/core/slrg_dp.sv
// slrg_dp: generator datapath - multiplier and Mersenne fold, bucket index,
// shuffle table memory, fraction and result register. Depends on slrg_pkg.
`timescale 1ns / 1ps

module slrg_dp #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slrg_pkg::t_ctrl    i_ctrl,
    input  logic               i_accept,
    input  logic               i_command,
    input  logic [30:0]        i_seed,
    input  logic               i_stall,
    output slrg_pkg::t_stat    o_stat,
    output logic               o_valid,
    output logic [30:0]        o_value,
    output logic [23:0]        o_fraction
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + slrg_pkg::WARMUP_STEPS);
    localparam longint unsigned BUCKET_L = 64'd1 + (64'd2147483646 / TABLE_DEPTH);
    localparam longint unsigned RECIP_L  = 64'd2147483648 / BUCKET_L;
    localparam logic [30:0]    BUCKET    = 31'(BUCKET_L);
    localparam logic [IDX_W:0] RECIP     = (IDX_W + 1)'(RECIP_L);
    localparam logic [CNT_W-1:0] CNT_TOP =
        CNT_W'(TABLE_DEPTH + slrg_pkg::WARMUP_STEPS - 1);
    localparam logic [IDX_W:0] DEPTH_W   = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_DEPTH - 1);

    logic              r_cmd;
    logic [30:0]       r_seed;
    logic [30:0]       r_state;
    logic [30:0]       r_held;
    logic [45:0]       r_prod;
    logic [IDX_W+31:0] r_qp;
    logic [IDX_W-1:0]  r_qe;
    logic [30:0]       r_qb;
    logic [CNT_W-1:0]  r_cnt;
    logic [30:0]       r_rd;
    logic              r_o_valid;
    logic [30:0]       r_o_value;
    logic [23:0]       r_o_frac;
    logic [30:0]       r_table [TABLE_DEPTH];

    logic [30:0]       n_seed;
    logic [31:0]       n_sum;
    logic [30:0]       n_fold;
    logic [IDX_W+30:0] n_qb;
    logic [30:0]       n_rem;
    logic [IDX_W:0]    n_idx_w;
    logic [IDX_W-1:0]  n_idx;
    logic [31:0]       n_fa;
    logic [24:0]       n_fq;
    logic [23:0]       n_frac;
    logic              n_we;
    logic [IDX_W-1:0]  n_waddr;
    logic [30:0]       n_wdata;
    logic              n_fill_hit;

    // zero and the modulus itself both map to seed 1
    assign n_seed = (r_cmd && r_seed != 31'd0 && r_seed != slrg_pkg::LCG_MOD)
                  ? r_seed : 31'd1;

    // 2^31 == 1 mod M: add high part to low part, one conditional subtract
    assign n_sum  = {1'b0, r_prod[30:0]} + {17'd0, r_prod[45:31]};
    assign n_fold = (n_sum >= {1'b0, slrg_pkg::LCG_MOD})
                  ? 31'(n_sum - {1'b0, slrg_pkg::LCG_MOD}) : n_sum[30:0];

    // quotient estimate is exact or one low; remainder check corrects it
    assign n_qb    = {{IDX_W{1'b0}}, BUCKET} * {31'd0, r_qp[31 +: IDX_W]};
    assign n_rem   = r_held - r_qb;
    assign n_idx_w = {1'b0, r_qe} + {{IDX_W{1'b0}}, (n_rem >= BUCKET)};
    assign n_idx   = (n_idx_w >= DEPTH_W) ? IDX_MAX : n_idx_w[IDX_W-1:0];

    // floor(v * 2^24 / M) = a + [a + b >= M], v*2^24 = a*2^31 + b
    assign n_fa   = {8'd0, r_rd[30:7]} + {1'b0, r_rd[6:0], 24'd0};
    assign n_fq   = {1'b0, r_rd[30:7]} + {24'd0, (n_fa >= {1'b0, slrg_pkg::LCG_MOD})};
    assign n_frac = (n_fq > {1'b0, slrg_pkg::FRAC_MAX}) ? slrg_pkg::FRAC_MAX : n_fq[23:0];

    assign n_fill_hit = i_ctrl.fill && (r_cnt < CNT_W'(TABLE_DEPTH));
    assign n_we       = n_fill_hit || i_ctrl.look;
    assign n_waddr    = i_ctrl.look ? n_idx : r_cnt[IDX_W-1:0];
    assign n_wdata    = i_ctrl.look ? r_state : n_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= 31'd0;
            r_held    <= 31'd0;
            r_o_valid <= 1'b0;
            r_cmd     <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (i_accept) begin
                r_cmd  <= i_command;
                r_seed <= i_seed;
            end
            if (i_ctrl.ld_seed) begin
                r_state <= n_seed;
                r_cnt   <= CNT_TOP;
            end
            if (i_ctrl.mul) begin
                r_prod <= {15'd0, r_state} * {31'd0, slrg_pkg::LCG_MUL};
                r_qp   <= {{(IDX_W + 1){1'b0}}, r_held} * {31'd0, RECIP};
            end
            if (i_ctrl.fold) begin
                r_state <= n_fold;
            end
            if (i_ctrl.fill) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (n_fill_hit) begin
                r_held <= n_fold;
            end
            if (i_ctrl.qmul) begin
                r_qe <= r_qp[31 +: IDX_W];
                r_qb <= n_qb[30:0];
            end
            if (i_ctrl.emit) begin
                r_held    <= r_rd;
                r_o_value <= r_rd;
                r_o_frac  <= n_frac;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // shuffle table: read-before-write on a swap
    always_ff @(posedge i_clk) begin
        if (i_ctrl.look) begin
            r_rd <= r_table[n_idx];
        end
        if (n_we) begin
            r_table[n_waddr] <= n_wdata;
        end
    end

    assign o_stat.need_seed = r_cmd || (r_state == 31'd0);
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.out_busy  = r_o_valid && i_stall;

    assign o_valid    = r_o_valid;
    assign o_value    = r_o_value;
    assign o_fraction = r_o_frac;

endmodule

### rtl/core/slrg_checker.sv
// slrg_checker: port-level assertions for the shuffled Lehmer generator,
// bound to the top level. Depends on shuffled_lehmer_random_generator.
`timescale 1ns / 1ps

module slrg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [30:0] o_value,
    input logic [23:0] o_fraction
);

    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_fraction))
        else $error("result changed while stalled");

    // generator output never zero nor the modulus
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value != 31'd0) && (o_value != 31'h7FFF_FFFF))
        else $error("value out of range");

    a_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fraction <= 24'd16777213)
        else $error("fraction above clamp");

    // one item at a time: input closes right after a transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input open after transfer");

    // a fresh result only follows an item in flight
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid ##1 o_valid |-> $past(o_stall))
        else $error("result without a pending item");

endmodule

bind shuffled_lehmer_random_generator slrg_checker u_slrg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_value    (o_value),
    .o_fraction (o_fraction)
);
